>>> hw/rtl/rgb_to_yuv420_converter_assert.svh
// Assertion macros used by the converter top level.
`ifndef RGB_TO_YUV420_CONVERTER_ASSERT_SVH
`define RGB_TO_YUV420_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RYC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define RYC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ryc_pkg.sv
// Types and fixed-point constants for the RGB to YUV 4:2:0 converter.
package ryc_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned FRAC     = 16;
  localparam int unsigned SUMW     = 27;
  localparam int unsigned COEF_W   = 18;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd384;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd216;

  // Q16 coefficients, rounded half away from zero
  localparam logic signed [COEF_W-1:0] Y_R_C  = 18'sd19595;
  localparam logic signed [COEF_W-1:0] Y_G_C  = 18'sd38470;
  localparam logic signed [COEF_W-1:0] Y_B_C  = 18'sd7471;
  localparam logic signed [COEF_W-1:0] CB_R_C = -18'sd11076;
  localparam logic signed [COEF_W-1:0] CB_G_C = -18'sd21692;
  localparam logic signed [COEF_W-1:0] CB_B_C = 18'sd29426;
  localparam logic signed [COEF_W-1:0] CR_R_C = 18'sd32702;
  localparam logic signed [COEF_W-1:0] CR_G_C = -18'sd27394;
  localparam logic signed [COEF_W-1:0] CR_B_C = -18'sd5328;

  // 128 << 16
  localparam logic signed [SUMW-1:0] CHROMA_OFS = 27'sd8388608;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
  } yuv_t;

  typedef struct packed {
    logic chroma;
    logic frame_end;
  } flag_t;

endpackage

>>> hw/rtl/rgb_to_yuv420_converter.sv
// Top level of the RGB24 to YUV 4:2:0 pixel converter (BT.601-style, point subsampled).
// Registers: input register, then result register, with the combinational Q16 matrix of
// ryc_csc between them. One pixel per cycle unless out_ready holds the result register.
// Reset: pipeline empties, row/column counters go to zero, frame size returns to
// 384 x 216 (limited to MAX_DIM). No clearing pass; the block is ready right after reset.
`include "rgb_to_yuv420_converter_assert.svh"

module rgb_to_yuv420_converter
  import ryc_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_red,
  input  logic [PIX_W-1:0]     in_green,
  input  logic [PIX_W-1:0]     in_blue,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_luma,
  output logic [PIX_W-1:0]     out_chroma_blue,
  output logic [PIX_W-1:0]     out_chroma_red,
  output logic                 out_chroma_valid,
  output logic                 out_frame_end,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Counter holds a position below MAX_DIM; limits go up to MAX_DIM itself.
  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned LW = $clog2(MAX_DIM + 1);
  // Width for comparing a raw register value against MAX_DIM.
  localparam int unsigned EW = (LW > CFG_W) ? LW : CFG_W;

  localparam int unsigned WID_RST_I =
      (int'(FRAME_WIDTH_RST) > MAX_DIM) ? MAX_DIM : int'(FRAME_WIDTH_RST);
  localparam int unsigned HGT_RST_I =
      (int'(FRAME_HEIGHT_RST) > MAX_DIM) ? MAX_DIM : int'(FRAME_HEIGHT_RST);
  localparam logic [LW-1:0] WID_LIM_RST = LW'(WID_RST_I);
  localparam logic [LW-1:0] HGT_LIM_RST = LW'(HGT_RST_I);

  // ------------------------------------------------------------------
  // Frame size. Stored already limited: zero reads as one, anything
  // above MAX_DIM as MAX_DIM.
  // ------------------------------------------------------------------
  logic [LW-1:0] wid_lim_r, wid_lim_nxt;
  logic [LW-1:0] hgt_lim_r, hgt_lim_nxt;
  logic [LW-1:0] cfg_lim;
  logic          cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_lim = LW'(1);
    end else if (EW'(cfg_data) > EW'(MAX_DIM)) begin
      cfg_lim = LW'(MAX_DIM);
    end else begin
      cfg_lim = LW'(cfg_data);
    end

    wid_lim_nxt = wid_lim_r;
    hgt_lim_nxt = hgt_lim_r;
    if (cfg_fire) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  wid_lim_nxt = cfg_lim;
        REG_FRAME_HEIGHT: hgt_lim_nxt = cfg_lim;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Pipeline handshake. Stage 1 is the input register, stage 2 the
  // result register; each advances when the stage after it has room.
  // ------------------------------------------------------------------
  logic s1_vld_r, out_vld_r;
  logic s1_adv, s2_adv, in_fire;

  assign s2_adv   = !out_vld_r || out_ready;
  assign s1_adv   = !s1_vld_r || s2_adv;
  assign in_ready = s1_adv;
  assign in_fire  = in_valid && in_ready;

  // ------------------------------------------------------------------
  // Raster position of the next pixel. Parity picks the chroma sites;
  // a counter at or past its limit (after a size change) wraps next.
  // ------------------------------------------------------------------
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic          col_last, row_last;
  flag_t         flag_nxt;

  always_comb begin
    col_last = (LW'(col_r) + LW'(1)) >= wid_lim_r;
    row_last = (LW'(row_r) + LW'(1)) >= hgt_lim_r;

    flag_nxt.chroma    = !col_r[0] && !row_r[0];
    flag_nxt.frame_end = col_last && row_last;

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // Control registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      col_r     <= '0;
      row_r     <= '0;
      wid_lim_r <= WID_LIM_RST;
      hgt_lim_r <= HGT_LIM_RST;
    end else begin
      if (s1_adv) begin
        s1_vld_r <= in_valid;
      end
      if (s2_adv) begin
        out_vld_r <= s1_vld_r;
      end
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      wid_lim_r <= wid_lim_nxt;
      hgt_lim_r <= hgt_lim_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Datapath: input register -> matrix -> result register
  // ------------------------------------------------------------------
  pix_t  pix_r;
  flag_t flag_r;
  yuv_t  yuv_c, yuv_r;
  flag_t out_flag_r;

  ryc_csc u_csc (
    .pix       (pix_r),
    .chroma_en (flag_r.chroma),
    .yuv       (yuv_c)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_r  <= '{red: in_red, green: in_green, blue: in_blue};
      flag_r <= flag_nxt;
    end
    if (s2_adv && s1_vld_r) begin
      yuv_r      <= yuv_c;
      out_flag_r <= flag_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_luma         = yuv_r.luma;
  assign out_chroma_blue  = yuv_r.chroma_blue;
  assign out_chroma_red   = yuv_r.chroma_red;
  assign out_chroma_valid = out_flag_r.chroma;
  assign out_frame_end    = out_flag_r.frame_end;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `RYC_ASSERT_NOW(a_no_chroma_off_grid, out_vld_r && !out_flag_r.chroma,
    out_chroma_blue == '0 && out_chroma_red == '0, "chroma on a non-chroma pixel")
  `RYC_ASSERT_NEXT(a_frame_wrap, in_fire && flag_nxt.frame_end,
    col_r == '0 && row_r == '0, "counters not cleared after frame end")
  `RYC_ASSERT_NEXT(a_col_step, in_fire && !col_last,
    col_r == $past(col_r) + CW'(1) && row_r == $past(row_r), "column step broken")

endmodule

>>> hw/rtl/ryc_csc.sv
// Color space matrix: Q16 weighted sums with clamp to 0..255.
module ryc_csc
  import ryc_pkg::*;
(
  input  pix_t pix,
  input  logic chroma_en,
  output yuv_t yuv
);

  function automatic logic [PIX_W-1:0] sat8(input logic signed [SUMW-1:0] s);
    logic [PIX_W-1:0] q;
    if (s[SUMW-1]) begin
      q = '0;
    end else if (|s[SUMW-2:FRAC+PIX_W]) begin
      q = '1;
    end else begin
      q = s[FRAC+PIX_W-1:FRAC];
    end
    return q;
  endfunction

  logic signed [SUMW-1:0] r_s, g_s, b_s;
  logic signed [SUMW-1:0] y_sum, cb_sum, cr_sum;

  always_comb begin
    r_s = SUMW'($signed({1'b0, pix.red}));
    g_s = SUMW'($signed({1'b0, pix.green}));
    b_s = SUMW'($signed({1'b0, pix.blue}));

    y_sum  = SUMW'(Y_R_C) * r_s + SUMW'(Y_G_C) * g_s + SUMW'(Y_B_C) * b_s;
    cb_sum = SUMW'(CB_R_C) * r_s + SUMW'(CB_G_C) * g_s + SUMW'(CB_B_C) * b_s
           + CHROMA_OFS;
    cr_sum = SUMW'(CR_R_C) * r_s + SUMW'(CR_G_C) * g_s + SUMW'(CR_B_C) * b_s
           + CHROMA_OFS;

    yuv.luma        = sat8(y_sum);
    // off-grid pixels carry zero chroma
    yuv.chroma_blue = chroma_en ? sat8(cb_sum) : '0;
    yuv.chroma_red  = chroma_en ? sat8(cr_sum) : '0;
  end

endmodule

>>> dv/yuv_scoreboard_pkg.sv
// Scoreboard class: predicts and checks the converter's YUV 4:2:0 results.
package yuv_scoreboard_pkg;
  import ryc_pkg::*;

  // indexes the block does not map; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

  localparam int unsigned DIM_CAP = 4096;

  // BT.601-like weights in signed Q16
  localparam int KY_R  = 19595;
  localparam int KY_G  = 38470;
  localparam int KY_B  = 7471;
  localparam int KU_R  = -11076;
  localparam int KU_G  = -21692;
  localparam int KU_B  = 29426;
  localparam int KV_R  = 32702;
  localparam int KV_G  = -27394;
  localparam int KV_B  = -5328;
  localparam int CHROMA_BIAS = 128 * 65536;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             chroma_valid;
    logic             frame_end;
  } yuv_sample_t;

  class yuv_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col;
    int unsigned      row;
    yuv_sample_t      expected_yuv[$];
    int unsigned      failures;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      col        = 0;
      row        = 0;
      failures   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = data;
        REG_FRAME_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    // zero means one, anything above the cap means the cap
    static function int unsigned dim_limit(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_CAP) return DIM_CAP;
      return 32'(v);
    endfunction

    // exact Q16 sum; negative -> 0, else truncate and saturate at 255
    static function logic [PIX_W-1:0] weigh(int kr, int kg, int kb, int bias, pix_t p);
      longint acc;
      longint q;
      acc = longint'(kr) * longint'(p.red) + longint'(kg) * longint'(p.green)
          + longint'(kb) * longint'(p.blue) + longint'(bias);
      if (acc < 0) return '0;
      q = acc >>> 16;
      if (q > 255) q = 255;
      return q[PIX_W-1:0];
    endfunction

    function void note_pixel(pix_t p);
      yuv_sample_t s;
      int unsigned w;
      int unsigned h;
      logic        last_col;
      logic        last_row;
      w = dim_limit(width_reg);
      h = dim_limit(height_reg);
      last_col = (col + 1 >= w);
      last_row = (row + 1 >= h);
      s.chroma_valid = !col[0] && !row[0];
      s.luma         = weigh(KY_R, KY_G, KY_B, 0, p);
      s.chroma_blue  = s.chroma_valid ? weigh(KU_R, KU_G, KU_B, CHROMA_BIAS, p) : '0;
      s.chroma_red   = s.chroma_valid ? weigh(KV_R, KV_G, KV_B, CHROMA_BIAS, p) : '0;
      s.frame_end    = last_col && last_row;
      if (last_col) begin
        col = 0;
        row = last_row ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
      expected_yuv.push_back(s);
    endfunction

    function void compare(string field, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_yuv(yuv_sample_t got);
      yuv_sample_t want;
      if (expected_yuv.size() == 0) begin
        $error("result with no pixel pending");
        failures++;
        return;
      end
      want = expected_yuv.pop_front();
      compare("luma", want.luma, got.luma);
      compare("chroma_blue", want.chroma_blue, got.chroma_blue);
      compare("chroma_red", want.chroma_red, got.chroma_red);
      compare("chroma_valid", PIX_W'(want.chroma_valid), PIX_W'(got.chroma_valid));
      compare("frame_end", PIX_W'(want.frame_end), PIX_W'(got.frame_end));
    endfunction

    function int unsigned pending();
      return expected_yuv.size();
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
// Testbench top: drives pixels and frame-size writes into the converter and checks results.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ryc_pkg::*;
  import yuv_scoreboard_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned GAP_PCT      = 30;    // idle share on each side, in percent
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned STEADY_PHASE = 4;     // random phase run with no idling
  localparam int unsigned STEADY_ITEMS = 250;
  localparam int unsigned LATENCY      = 2;
  localparam int unsigned END_PAUSE    = 8 * LATENCY;
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no request moving at all

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] in_red = '0;
  logic [PIX_W-1:0] in_green = '0;
  logic [PIX_W-1:0] in_blue = '0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] out_luma;
  logic [PIX_W-1:0] out_chroma_blue;
  logic [PIX_W-1:0] out_chroma_red;
  logic             out_chroma_valid;
  logic             out_frame_end;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // cleared for one stretch of the run so that both sides go flat out
  bit          gaps_on = 1'b1;
  int unsigned random_items = 0;
  int unsigned quiet_cycles = 0;

  yuv_scoreboard sb = new();

  rgb_to_yuv420_converter #(
    .MAX_DIM(DIM_CAP)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_luma         (out_luma),
    .out_chroma_blue  (out_chroma_blue),
    .out_chroma_red   (out_chroma_red),
    .out_chroma_valid (out_chroma_valid),
    .out_frame_end    (out_frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side: ready toggles at the falling edge, results are taken at the rising edge.
  always @(negedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= GAP_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_yuv('{luma: out_luma, chroma_blue: out_chroma_blue,
                     chroma_red: out_chroma_red, chroma_valid: out_chroma_valid,
                     frame_end: out_frame_end});
    end
  end

  // Watchdog: any request moving on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one pixel request and hold it until taken. Valid is left high on exit so
  // back-to-back requests never lower and raise it in the same step; a gap or
  // end_burst lowers it.
  task automatic push_pixel(input pix_t p);
    while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= p.red;
    in_green <= p.green;
    in_blue  <= p.blue;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic push_rgb(input int r, input int g, input int b);
    pix_t p;
    p.red   = r[PIX_W-1:0];
    p.green = g[PIX_W-1:0];
    p.blue  = b[PIX_W-1:0];
    push_pixel(p);
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic end_burst();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // One register write request; valid stays high for a following write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Mostly uniform components, with a share of pure 0/255 corners.
  function automatic pix_t random_pixel();
    pix_t p;
    if ($urandom_range(0, 4) == 0) begin
      p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      p.red   = PIX_W'($urandom_range(0, 255));
      p.green = PIX_W'($urandom_range(0, 255));
      p.blue  = PIX_W'($urandom_range(0, 255));
    end
    return p;
  endfunction

  task automatic run_pixels(input int unsigned n);
    repeat (n) push_pixel(random_pixel());
    end_burst();
  endtask

  initial begin
    logic [CFG_W-1:0]     w;
    logic [CFG_W-1:0]     h;
    logic [CFG_IDX_W-1:0] spare;
    int unsigned          n;
    int unsigned          phase;
    int unsigned          pick;

    // synchronous reset, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corners at the reset size (384 x 216), row 0: black, white and red each on an even
    // and an odd column, so chroma is seen both computed and blanked.
    push_rgb(0, 0, 0);
    push_rgb(0, 0, 0);
    push_rgb(255, 255, 255);
    push_rgb(255, 255, 255);
    push_rgb(255, 0, 0);
    push_rgb(0, 255, 0);
    push_rgb(0, 0, 255);
    push_rgb(255, 0, 0);
    push_rgb(255, 255, 0);
    push_rgb(0, 255, 255);
    end_burst();

    // 2 x 2 frame: odd rows appear, frame end every fourth pixel
    set_frame(2, 2);
    run_pixels(5);

    // zero size acts as 1 x 1: every pixel ends a frame; once the counters wrap, every pixel carries chroma
    set_frame(0, 0);
    run_pixels(2);

    // odd width: chroma follows the counters, not the pixel index
    set_frame(3, 3);
    run_pixels(7);

    // oversize clamps to the cap
    set_frame(13'h1FFF, 13'h1FFF);
    run_pixels(3);

    // shrink mid-frame: column already past the new width wraps at once
    set_frame(2, 1);
    run_pixels(3);

    // unmapped indexes are ignored
    spare = CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
    cfg_write(REG_SPARE_LAST, 13'h1FFF);
    cfg_write(spare, CFG_W'($urandom_range(0, 13'h1FFF)));
    cfg_valid <= 1'b0;
    run_pixels(2);

    // Random phases: a new frame size each time, often only one register so the
    // counters meet a size change in the middle of a frame.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        w = CFG_W'($urandom_range(0, 13'h1FFF));
        h = CFG_W'($urandom_range(0, 13'h1FFF));
      end else if (pick == 1) begin
        w = CFG_W'(DIM_CAP);
        h = CFG_W'($urandom_range(1, 3));
      end else if (pick == 2) begin
        w = CFG_W'($urandom_range(0, 25));
        h = CFG_W'($urandom_range(0, 6));
      end else begin
        w = CFG_W'(2 * $urandom_range(1, 12));
        h = CFG_W'($urandom_range(1, 8));
      end
      case ($urandom_range(0, 3))
        0: cfg_write(REG_FRAME_WIDTH, w);
        1: cfg_write(REG_FRAME_HEIGHT, h);
        default: begin
          cfg_write(REG_FRAME_WIDTH, w);
          cfg_write(REG_FRAME_HEIGHT, h);
        end
      endcase
      cfg_valid <= 1'b0;
      gaps_on = (phase != STEADY_PHASE);
      n = gaps_on ? $urandom_range(10, 100) : STEADY_ITEMS;
      run_pixels(n);
      random_items += n;
      phase++;
    end
    gaps_on = 1'b1;

    // anything arriving late still reaches the checker during this pause
    repeat (END_PAUSE) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
